@@ design/hmp_pkg.sv @@
// ----------------------------------------------------------------------------
// hmp_pkg
// Shared types and constants for the hash message padder.
// ----------------------------------------------------------------------------
package hmp_pkg;

    // The padding byte that follows the last message byte.
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // The block holds 16 words. The length occupies words 14 and 15.
    localparam logic [3:0] LAST_FILL_IDX = 4'd13;
    localparam logic [4:0] NEXT_BLOCK_FILL = 5'd29;

    // Byte offset within a block at which the closing byte completes word 13.
    // A message that ends there owes one word more than a single item may return.
    localparam logic [5:0] TAIL_WRAP_OFFSET = 6'd55;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA,
        ST_PAD,
        ST_ZERO,
        ST_LEN1,
        ST_LEN2,
        ST_PARK,
        ST_FLUSH
    } hmp_state_t;

    typedef enum logic [2:0] {
        SEL_BUF,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN_A,
        SEL_LEN_B,
        SEL_HOLD
    } word_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      accept;
        logic      clr_word;
        logic      load_zeros;
        logic      dec_zeros;
        logic      latch_hold;
        logic      clr_msg;
        word_sel_t sel;
    } hmp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lane_last;
        logic tail_wrap;
        logic zeros_none;
        logic zcnt_one;
    } hmp_stat_t;

endpackage

@@ design/hmp_datapath.sv @@
// ----------------------------------------------------------------------------
// hmp_datapath
// Byte packing, message byte count, zero fill counter and output word mux.
// ----------------------------------------------------------------------------
module hmp_datapath #(
    parameter int COUNT_WIDTH = 61
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic [7:0]        data_byte,
    input  logic              byte_valid,
    input  hmp_pkg::hmp_cmd_t cmd,
    output hmp_pkg::hmp_stat_t stat,
    output logic [31:0]       block_word
);
    import hmp_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [31:0]            buf_reg, buf_next;
    logic [3:0]             zcnt_reg, zcnt_next;
    logic [31:0]            hold_reg;
    logic                   high_first_reg;

    logic [1:0]  pos;
    logic [3:0]  word_idx;
    logic [3:0]  zeros;
    logic [63:0] bit_len;
    logic [31:0] len_a, len_b;

    assign pos      = count_reg[1:0];
    assign word_idx = count_reg[5:2];
    assign bit_len  = 64'(count_reg) << 3;
    assign len_a    = high_first_reg ? bit_len[63:32] : bit_len[31:0];
    assign len_b    = high_first_reg ? bit_len[31:0] : bit_len[63:32];

    // Zero words between the padding word and the length words.
    always_comb begin
        if (word_idx <= LAST_FILL_IDX) begin
            zeros = LAST_FILL_IDX - word_idx;
        end else begin
            zeros = 4'(NEXT_BLOCK_FILL - {1'b0, word_idx});
        end
    end

    always_comb begin
        count_next = count_reg;
        buf_next   = buf_reg;
        zcnt_next  = zcnt_reg;
        if (cmd.accept && byte_valid) begin
            buf_next   = buf_reg | (32'(data_byte) << {pos, 3'b000});
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        if (cmd.clr_word) begin
            buf_next = '0;
        end
        if (cmd.clr_msg) begin
            buf_next   = '0;
            count_next = '0;
        end
        if (cmd.load_zeros) begin
            zcnt_next = zeros;
        end else if (cmd.dec_zeros) begin
            zcnt_next = zcnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            buf_reg        <= '0;
            zcnt_reg       <= '0;
            high_first_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            buf_reg   <= buf_next;
            zcnt_reg  <= zcnt_next;
            if (cfg_we) begin
                high_first_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_hold) begin
            hold_reg <= len_b;
        end
    end

    always_comb begin
        unique case (cmd.sel)
            SEL_BUF:   block_word = buf_reg;
            SEL_PAD:   block_word = buf_reg | (32'(PAD_BYTE) << {pos, 3'b000});
            SEL_ZERO:  block_word = '0;
            SEL_LEN_A: block_word = len_a;
            SEL_LEN_B: block_word = len_b;
            SEL_HOLD:  block_word = hold_reg;
            default:   block_word = '0;
        endcase
    end

    assign stat.lane_last  = (pos == 2'b11);
    assign stat.tail_wrap  = (count_reg[5:0] == TAIL_WRAP_OFFSET);
    assign stat.zeros_none = (zeros == 4'd0);
    assign stat.zcnt_one   = (zcnt_reg == 4'd1);

endmodule

@@ design/hmp_ctrl.sv @@
// ----------------------------------------------------------------------------
// hmp_ctrl
// Controller that steps through data, padding, zero fill and length words.
// ----------------------------------------------------------------------------
module hmp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               byte_valid,
    input  logic               end_of_message,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_tlast,
    input  hmp_pkg::hmp_stat_t stat,
    output hmp_pkg::hmp_cmd_t  cmd
);
    import hmp_pkg::*;

    hmp_state_t state_reg, state_next;
    logic       end_reg, end_next;
    logic       full_reg, full_next;
    logic       defer_reg, defer_next;

    logic in_fire;
    logic out_fire;
    logic full_in;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign full_in  = byte_valid && stat.lane_last;

    always_comb begin
        state_next = state_reg;
        end_next   = end_reg;
        full_next  = full_reg;
        defer_next = defer_reg;
        if (in_fire) begin
            end_next   = end_of_message;
            full_next  = full_in;
            defer_next = full_in && end_of_message && stat.tail_wrap;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (full_in) begin
                        state_next = ST_DATA;
                    end else if (end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PARK: begin
                if (in_fire) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_fire) begin
                    if (full_reg) begin
                        state_next = ST_DATA;
                    end else if (end_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DATA: begin
                if (out_fire) begin
                    state_next = end_reg ? ST_PAD : ST_IDLE;
                end
            end
            ST_PAD: begin
                if (out_fire) begin
                    state_next = stat.zeros_none ? ST_LEN1 : ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (out_fire && stat.zcnt_one) begin
                    state_next = ST_LEN1;
                end
            end
            ST_LEN1: begin
                if (out_fire) begin
                    state_next = defer_reg ? ST_PARK : ST_LEN2;
                end
            end
            ST_LEN2: begin
                if (out_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        m_tlast        = 1'b0;
        cmd.accept     = in_fire;
        cmd.clr_word   = 1'b0;
        cmd.load_zeros = 1'b0;
        cmd.dec_zeros  = 1'b0;
        cmd.latch_hold = 1'b0;
        cmd.clr_msg    = 1'b0;
        cmd.sel        = SEL_ZERO;
        unique case (state_reg)
            ST_IDLE, ST_PARK: begin
                s_tready = 1'b1;
            end
            ST_FLUSH: begin
                m_tvalid = 1'b1;
                m_tlast  = 1'b1;
                cmd.sel  = SEL_HOLD;
            end
            ST_DATA: begin
                m_tvalid     = 1'b1;
                cmd.sel      = SEL_BUF;
                cmd.clr_word = out_fire;
            end
            ST_PAD: begin
                m_tvalid       = 1'b1;
                cmd.sel        = SEL_PAD;
                cmd.load_zeros = out_fire;
            end
            ST_ZERO: begin
                m_tvalid      = 1'b1;
                cmd.sel       = SEL_ZERO;
                cmd.dec_zeros = out_fire;
            end
            ST_LEN1: begin
                m_tvalid       = 1'b1;
                cmd.sel        = SEL_LEN_A;
                cmd.latch_hold = out_fire && defer_reg;
                cmd.clr_msg    = out_fire && defer_reg;
            end
            ST_LEN2: begin
                m_tvalid    = 1'b1;
                m_tlast     = 1'b1;
                cmd.sel     = SEL_LEN_B;
                cmd.clr_msg = out_fire;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            end_reg   <= 1'b0;
            full_reg  <= 1'b0;
            defer_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            end_reg   <= end_next;
            full_reg  <= full_next;
            defer_reg <= defer_next;
        end
    end

    // Input and output are never open in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input and output open together");

    // A deferred length word always parks the controller.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEN1 && out_fire && defer_reg) |=> (state_reg == ST_PARK))
        else $error("deferred length word did not park");

    // A deferred tail only arises from a full word that ends the message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        defer_reg |-> (full_reg && end_reg))
        else $error("defer flag without a closing full word");

    // The parked word is flushed right after the next item is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PARK && in_fire) |=> (state_reg == ST_FLUSH))
        else $error("parked word not flushed first");

endmodule

@@ design/hash_message_padder.sv @@
// ----------------------------------------------------------------------------
// hash_message_padder
// MD5/SHA style message padding of a byte stream into 512-bit blocks.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | tdata: data_byte; tuser: byte_valid, end_of_message
//  m_*      | out       | tdata: block_word; tlast: last_word
//  cfg_*    | in        | cfg_wdata: length_high_first
//
// An item that completes no word and has no end mark gives no output. An item
// that completes a word holds the input for one more transaction on the output.
// An item with the end mark produces the padding word, zero fill and two length
// words, one per cycle while m_tready is high, up to 18 words; the controller
// steps through them state by state over the single output port.
// When a message ends with the byte that completes word 13 of a block, the
// final length word is kept and sent as the first transaction after the next
// accepted input item. Reset is synchronous and active low; no clearing pass.
// Stalls on m_tready simply hold the current word; input waits meanwhile.
//
module hash_message_padder #(
    parameter int COUNT_WIDTH = 61
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,   // length_high_first
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic [1:0]  s_tuser,     // [0] byte_valid, [1] end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] block_word
    output logic        m_tlast      // last_word
);
    import hmp_pkg::*;

    hmp_cmd_t  cmd;
    hmp_stat_t stat;

    // The controller sequences the words of each transaction's results.
    hmp_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .byte_valid     (s_tuser[0]),
        .end_of_message (s_tuser[1]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tlast        (m_tlast),
        .stat           (stat),
        .cmd            (cmd)
    );

    // The datapath packs bytes, counts the message and forms each word.
    hmp_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .data_byte  (s_tdata),
        .byte_valid (s_tuser[0]),
        .cmd        (cmd),
        .stat       (stat),
        .block_word (m_tdata)
    );

endmodule
